@@ rtl/hrzm_pkg.sv @@
// ----------------------------------------------------------------------------
// hrzm_pkg
// shared constants, codes and tables of the haversine range and zone monitor
// ----------------------------------------------------------------------------
package hrzm_pkg;

    // cordic depth, capped at the length of the arctangent table
    localparam int CORDIC_STAGES = 24;
    localparam int CORDIC_N      = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

    // one square-root stage per result bit of a 61-bit radicand
    localparam int ISQRT_STAGES  = 31;

    // cordic datapath width (angles and vectors)
    localparam int CW = 34;

    // pipeline positions: last stage before the output register, and the
    // length of the side-band delay line that runs beside the trig path
    localparam int VLD_LAST = 15 + ISQRT_STAGES + 2 * CORDIC_N;
    localparam int SIDE_LEN = 12 + ISQRT_STAGES + 2 * CORDIC_N;

    // fixed-point constants (radians Q30, degree factor Q36)
    localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [CW-1:0] TWO_PI_Q30  = 34'sd6746518852;
    localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [CW-1:0] INV_GAIN    = 34'sd652032874;
    localparam logic signed [32:0]   DEG_K36     = 33'sd1199381129;

    // earth radius over one nautical mile, Q16
    localparam logic [27:0] RADIUS_Q16 = 28'd225448086;
    localparam logic [21:0] DIST_MAX   = 22'd2766667;

    // feet conversion: milli-feet per metre, and floor(n/1000) by reciprocal
    localparam logic signed [28:0] FT_PER_M_MILLI = 29'sd3281;
    localparam logic [30:0]        RECIP_1000     = 31'd1099511628;
    localparam int                 RECIP_SHIFT    = 40;
    localparam logic signed [29:0] FT_BIAS_MILLI  = 30'sd108000000;
    localparam logic [18:0]        FT_BIAS        = 19'd108000;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_REF_LAT      = 3'd0,
        REG_REF_LON      = 3'd1,
        REG_OUTER_RADIUS = 3'd2,
        REG_INNER_RADIUS = 3'd3,
        REG_CEILING_FT   = 3'd4,
        REG_FLOOR_FT     = 3'd5
    } cfg_idx_t;

    // zone event codes
    typedef enum logic [1:0] {
        ZONE_NONE  = 2'd0,
        ZONE_RING  = 2'd1,
        ZONE_CLIMB = 2'd2,
        ZONE_LEFT  = 2'd3
    } zone_t;

    // atan(2^-i) in Q30, rounded
    function automatic logic [31:0] atan_q30(input int unsigned i);
        logic [31:0] v;
        case (i)
            0:       v = 32'd843314857;
            1:       v = 32'd497837829;
            2:       v = 32'd263043837;
            3:       v = 32'd133525159;
            4:       v = 32'd67021687;
            5:       v = 32'd33543516;
            6:       v = 32'd16775851;
            7:       v = 32'd8388437;
            8:       v = 32'd4194283;
            9:       v = 32'd2097149;
            default: v = (i <= 30) ? (32'd1 << (30 - i)) : 32'd1;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/hrzm_if.sv @@
// ----------------------------------------------------------------------------
// hrzm interfaces
// report, result and configuration channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface hrzm_report_if;
    logic               valid;
    logic               ready;
    logic signed [27:0] lat_deg;
    logic signed [28:0] lon_deg;
    logic signed [15:0] alt_m;
    logic signed [15:0] vert_rate;

    modport source (output valid, lat_deg, lon_deg, alt_m, vert_rate, input ready);
    modport sink   (input valid, lat_deg, lon_deg, alt_m, vert_rate, output ready);
endinterface

interface hrzm_result_if;
    logic               valid;
    logic               ready;
    logic        [21:0] distance_nm;
    logic signed [17:0] alt_ft;
    logic        [1:0]  zone_event;

    modport source (output valid, distance_nm, alt_ft, zone_event, input ready);
    modport sink   (input valid, distance_nm, alt_ft, zone_event, output ready);
endinterface

interface hrzm_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [28:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/hrzm_cordic.sv @@
// ----------------------------------------------------------------------------
// hrzm_cordic
// unrolled circular cordic, one micro-rotation per register stage
// ----------------------------------------------------------------------------
module hrzm_cordic (
    input  logic                            clk,
    input  logic                            en,
    input  logic                            vect,
    input  logic signed [hrzm_pkg::CW-1:0]  x_in,
    input  logic signed [hrzm_pkg::CW-1:0]  y_in,
    input  logic signed [hrzm_pkg::CW-1:0]  z_in,
    input  logic                            tag_in,
    output logic signed [hrzm_pkg::CW-1:0]  x_out,
    output logic signed [hrzm_pkg::CW-1:0]  y_out,
    output logic signed [hrzm_pkg::CW-1:0]  z_out,
    output logic                            tag_out
);

    localparam int N = hrzm_pkg::CORDIC_N;
    localparam int W = hrzm_pkg::CW;

    logic signed [W-1:0] x_reg [0:N-1];
    logic signed [W-1:0] y_reg [0:N-1];
    logic signed [W-1:0] z_reg [0:N-1];
    logic                tag_reg [0:N-1];

    genvar k;
    for (k = 0; k < N; k++) begin : g_stage
        logic signed [W-1:0] xp, yp, zp;
        logic                tp;
        logic signed [W-1:0] ang;
        logic                dir;

        if (k == 0) begin : g_first
            assign xp = x_in;
            assign yp = y_in;
            assign zp = z_in;
            assign tp = tag_in;
        end
        else begin : g_rest
            assign xp = x_reg[k-1];
            assign yp = y_reg[k-1];
            assign zp = z_reg[k-1];
            assign tp = tag_reg[k-1];
        end

        assign ang = W'(hrzm_pkg::atan_q30(k));
        // rotation follows the residual angle, vectoring drives y to zero
        assign dir = vect ? (yp <= 0) : (zp >= 0);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (dir)
                begin
                    x_reg[k] <= xp - (yp >>> k);
                    y_reg[k] <= yp + (xp >>> k);
                    z_reg[k] <= zp - ang;
                end
                else
                begin
                    x_reg[k] <= xp + (yp >>> k);
                    y_reg[k] <= yp - (xp >>> k);
                    z_reg[k] <= zp + ang;
                end
                tag_reg[k] <= tp;
            end
        end
    end

    assign x_out   = x_reg[N-1];
    assign y_out   = y_reg[N-1];
    assign z_out   = z_reg[N-1];
    assign tag_out = tag_reg[N-1];

endmodule

@@ rtl/hrzm_isqrt.sv @@
// ----------------------------------------------------------------------------
// hrzm_isqrt
// pipelined floor square root, one result bit per register stage
// ----------------------------------------------------------------------------
module hrzm_isqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [60:0] v_in,
    output logic [30:0] root
);

    localparam int N = hrzm_pkg::ISQRT_STAGES;

    logic [61:0] v_reg [0:N-1];
    logic [61:0] r_reg [0:N-1];

    genvar k;
    for (k = 0; k < N; k++) begin : g_stage
        logic [61:0] vp, rp;
        logic [62:0] t;
        localparam logic [61:0] BIT = 62'd1 << (2 * (N - 1 - k));

        if (k == 0) begin : g_first
            assign vp = 62'(v_in);
            assign rp = '0;
        end
        else begin : g_rest
            assign vp = v_reg[k-1];
            assign rp = r_reg[k-1];
        end

        assign t = 63'(rp) + 63'(BIT);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (63'(vp) >= t)
                begin
                    v_reg[k] <= vp - t[61:0];
                    r_reg[k] <= (rp >> 1) + BIT;
                end
                else
                begin
                    v_reg[k] <= vp;
                    r_reg[k] <= rp >> 1;
                end
            end
        end
    end

    assign root = r_reg[N-1][30:0];

endmodule

@@ rtl/haversine_range_zone_monitor_core.sv @@
// ----------------------------------------------------------------------------
// haversine_range_zone_monitor_core
// great-circle range of each position report to a reference point, feet
// conversion and zone event classification, fully pipelined
// ----------------------------------------------------------------------------
//
//  channel  | dir | role
//  ---------+-----+--------------------------------------------------------
//  report   | in  | lat_deg, lon_deg (deg Q20), alt_m, vert_rate
//  result   | out | distance_nm (1/256 nm), alt_ft, zone_event
//  cfg      | in  | index + data, register write, always ready
//
//  one report per cycle sustained while result is ready; the path runs through
//  the four parallel sine/cosine cordics, the 31-stage square roots and the
//  arctangent cordic in series
//  reset clears the valid line and presets the configuration registers
//  a stall on result freezes every stage at once; report.ready drops only
//  while a finished transaction waits on result
//
module haversine_range_zone_monitor_core (
    input  logic           clk,
    input  logic           rst_n,
    hrzm_report_if.sink    report,
    hrzm_result_if.source  result,
    hrzm_cfg_if.sink       cfg
);

    localparam int N  = hrzm_pkg::CORDIC_N;
    localparam int W  = hrzm_pkg::CW;
    localparam int VL = hrzm_pkg::VLD_LAST;
    localparam int SL = hrzm_pkg::SIDE_LEN;

    localparam logic signed [63:0] ONE_Q60 = 64'sd1 <<< 60;

    // altitude side-band carried beside the trig path
    typedef struct packed {
        logic signed [17:0] alt_ft;
        logic               le_ceil;
        logic               ge_floor;
        logic               vr_pos;
    } side_t;

    // round half away from zero, then arithmetic shift
    function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                   input int unsigned s);
        logic signed [63:0] h;
        h = 64'(64'd1 << (s - 1));
        return (v + (v[63] ? (h - 64'sd1) : h)) >>> s;
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic signed [27:0] ref_lat_reg;
    logic signed [28:0] ref_lon_reg;
    logic        [21:0] outer_reg;
    logic        [21:0] inner_reg;
    logic        [16:0] ceiling_reg;
    logic        [16:0] floor_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_lat_reg <= 28'sd45798759;
            ref_lon_reg <= -29'sd83501672;
            outer_reg   <= 22'd2048;
            inner_reg   <= 22'd1920;
            ceiling_reg <= 17'd3000;
            floor_reg   <= 17'd2500;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                hrzm_pkg::REG_REF_LAT:      ref_lat_reg <= cfg.data[27:0];
                hrzm_pkg::REG_REF_LON:      ref_lon_reg <= cfg.data;
                hrzm_pkg::REG_OUTER_RADIUS: outer_reg   <= cfg.data[21:0];
                hrzm_pkg::REG_INNER_RADIUS: inner_reg   <= cfg.data[21:0];
                hrzm_pkg::REG_CEILING_FT:   ceiling_reg <= cfg.data[16:0];
                hrzm_pkg::REG_FLOOR_FT:     floor_reg   <= cfg.data[16:0];
                default:                    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // global advance and valid line
    // ------------------------------------------------------------------
    logic          en;
    logic [VL:1]   vld_reg;
    logic          out_vld_reg;

    assign en           = !out_vld_reg || result.ready;
    assign report.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[VL-1:1], report.valid};
            out_vld_reg <= vld_reg[VL];
        end
    end

    // ------------------------------------------------------------------
    // stage A: capture the report
    // ------------------------------------------------------------------
    logic signed [27:0] a_lat_reg;
    logic signed [28:0] a_lon_reg;
    logic signed [15:0] a_alt_reg;
    logic signed [15:0] a_vr_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_lat_reg <= report.lat_deg;
            a_lon_reg <= report.lon_deg;
            a_alt_reg <= report.alt_m;
            a_vr_reg  <= report.vert_rate;
        end
    end

    // ------------------------------------------------------------------
    // stage B: coordinate differences, altitude in milli-feet
    // ------------------------------------------------------------------
    logic signed [28:0] b_dlat_reg;
    logic signed [29:0] b_dlon_reg;
    logic signed [27:0] b_lat_reg;
    logic signed [27:0] b_rlat_reg;
    logic signed [28:0] b_ftm_reg;
    logic               b_vr_pos_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_dlat_reg   <= 29'(a_lat_reg) - 29'(ref_lat_reg);
            b_dlon_reg   <= 30'(a_lon_reg) - 30'(ref_lon_reg);
            b_lat_reg    <= a_lat_reg;
            b_rlat_reg   <= ref_lat_reg;
            b_ftm_reg    <= 29'(a_alt_reg) * hrzm_pkg::FT_PER_M_MILLI;
            b_vr_pos_reg <= (a_vr_reg > 16'sd0);
        end
    end

    // ------------------------------------------------------------------
    // stage C: degree to radian products, feet rounding product, band flags
    // ------------------------------------------------------------------
    logic signed [61:0] c_prod_reg [4];
    logic        [58:0] c_q_reg;
    logic               c_le_ceil_reg;
    logic               c_ge_floor_reg;
    logic               c_vr_pos_reg;

    logic signed [29:0] c_n_next;
    logic        [26:0] ceil_milli;
    logic        [26:0] floor_milli;

    // offset keeps the dividend positive, rounding bias picks the side
    assign c_n_next = 30'(b_ftm_reg) + hrzm_pkg::FT_BIAS_MILLI
                    + (b_ftm_reg[28] ? 30'sd499 : 30'sd500);
    assign ceil_milli  = 27'(ceiling_reg) * 27'd1000;
    assign floor_milli = 27'(floor_reg) * 27'd1000;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_prod_reg[0]  <= 62'(b_dlat_reg) * 62'(hrzm_pkg::DEG_K36);
            c_prod_reg[1]  <= 62'(b_dlon_reg) * 62'(hrzm_pkg::DEG_K36);
            c_prod_reg[2]  <= 62'(b_lat_reg) * 62'(hrzm_pkg::DEG_K36);
            c_prod_reg[3]  <= 62'(b_rlat_reg) * 62'(hrzm_pkg::DEG_K36);
            c_q_reg        <= 59'(c_n_next[27:0]) * 59'(hrzm_pkg::RECIP_1000);
            c_le_ceil_reg  <= (b_ftm_reg <= $signed({2'b00, ceil_milli}));
            c_ge_floor_reg <= (b_ftm_reg >= $signed({2'b00, floor_milli}));
            c_vr_pos_reg   <= b_vr_pos_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage D: rounded angles (half angles for the differences)
    // ------------------------------------------------------------------
    logic signed [W-1:0] d_ang_reg [4];
    side_t               side_reg [0:SL-1];
    side_t               d_side_next;
    logic        [18:0]  d_ft_next;

    assign d_ft_next = c_q_reg[58:hrzm_pkg::RECIP_SHIFT] - hrzm_pkg::FT_BIAS;

    always_comb
    begin
        d_side_next.alt_ft   = d_ft_next[17:0];
        d_side_next.le_ceil  = c_le_ceil_reg;
        d_side_next.ge_floor = c_ge_floor_reg;
        d_side_next.vr_pos   = c_vr_pos_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                d_ang_reg[i] <= W'(rnd_shr(64'(c_prod_reg[i]), (i < 2) ? 27 : 26));
            end
            side_reg[0] <= d_side_next;
            for (int j = 1; j < SL; j++)
            begin
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage E: wrap to (-pi, pi]; stage F: fold to [-pi/2, pi/2]
    // ------------------------------------------------------------------
    logic signed [W-1:0] e_ang_reg [4];
    logic signed [W-1:0] f_ang_reg [4];
    logic                f_flip_reg [4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (d_ang_reg[i] > hrzm_pkg::PI_Q30)
                    e_ang_reg[i] <= d_ang_reg[i] - hrzm_pkg::TWO_PI_Q30;
                else if (d_ang_reg[i] <= -hrzm_pkg::PI_Q30)
                    e_ang_reg[i] <= d_ang_reg[i] + hrzm_pkg::TWO_PI_Q30;
                else
                    e_ang_reg[i] <= d_ang_reg[i];

                if (e_ang_reg[i] > hrzm_pkg::HALF_PI_Q30)
                begin
                    f_ang_reg[i]  <= e_ang_reg[i] - hrzm_pkg::PI_Q30;
                    f_flip_reg[i] <= 1'b1;
                end
                else if (e_ang_reg[i] < -hrzm_pkg::HALF_PI_Q30)
                begin
                    f_ang_reg[i]  <= e_ang_reg[i] + hrzm_pkg::PI_Q30;
                    f_flip_reg[i] <= 1'b1;
                end
                else
                begin
                    f_ang_reg[i]  <= e_ang_reg[i];
                    f_flip_reg[i] <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // sine/cosine cordics: half dlat, half dlon, lat, reference lat
    // ------------------------------------------------------------------
    logic signed [W-1:0] rot_x [4];
    logic signed [W-1:0] rot_y [4];
    logic                rot_flip [4];

    for (genvar g = 0; g < 4; g++) begin : g_rot
        hrzm_cordic u_rot (
            .clk     (clk),
            .en      (en),
            .vect    (1'b0),
            .x_in    (hrzm_pkg::INV_GAIN),
            .y_in    ('0),
            .z_in    (f_ang_reg[g]),
            .tag_in  (f_flip_reg[g]),
            .x_out   (rot_x[g]),
            .y_out   (rot_y[g]),
            .z_out   (),
            .tag_out (rot_flip[g])
        );
    end

    // ------------------------------------------------------------------
    // stage G: undo the fold; sin(dlat/2), sin(dlon/2), cos(lat), cos(ref)
    // ------------------------------------------------------------------
    logic signed [31:0] g_s1_reg, g_s2_reg, g_cp_reg, g_cr_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_s1_reg <= 32'(rot_flip[0] ? -rot_y[0] : rot_y[0]);
            g_s2_reg <= 32'(rot_flip[1] ? -rot_y[1] : rot_y[1]);
            g_cp_reg <= 32'(rot_flip[2] ? -rot_x[2] : rot_x[2]);
            g_cr_reg <= 32'(rot_flip[3] ? -rot_x[3] : rot_x[3]);
        end
    end

    // ------------------------------------------------------------------
    // stages H..L: haversine term a in Q60, clamped, and 1 - a
    // ------------------------------------------------------------------
    logic signed [63:0] h_s1sq_reg, h_cpcr_reg, h_s2sq_reg;
    logic signed [63:0] i_s1sq_reg;
    logic signed [33:0] i_t1_reg, i_t2_reg;
    logic signed [63:0] j_s1sq_reg, j_pr_reg;
    logic signed [63:0] k_sum_reg;
    logic        [60:0] l_a_reg, l_b_reg;
    logic signed [63:0] l_b_raw;

    assign l_b_raw = ONE_Q60 - k_sum_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_s1sq_reg <= 64'(g_s1_reg) * 64'(g_s1_reg);
            h_cpcr_reg <= 64'(g_cp_reg) * 64'(g_cr_reg);
            h_s2sq_reg <= 64'(g_s2_reg) * 64'(g_s2_reg);

            i_s1sq_reg <= h_s1sq_reg;
            i_t1_reg   <= 34'(rnd_shr(h_cpcr_reg, 30));
            i_t2_reg   <= 34'(rnd_shr(h_s2sq_reg, 30));

            j_s1sq_reg <= i_s1sq_reg;
            j_pr_reg   <= 64'(i_t1_reg) * 64'(i_t2_reg);

            k_sum_reg  <= j_s1sq_reg + j_pr_reg;

            if (k_sum_reg < 0)
            begin
                l_a_reg <= '0;
                l_b_reg <= ONE_Q60[60:0];
            end
            else if (k_sum_reg > ONE_Q60)
            begin
                l_a_reg <= ONE_Q60[60:0];
                l_b_reg <= '0;
            end
            else
            begin
                l_a_reg <= k_sum_reg[60:0];
                l_b_reg <= l_b_raw[60:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // square roots, then atan2(sqrt a, sqrt(1 - a)) by vectoring cordic
    // ------------------------------------------------------------------
    logic [30:0]         sqrt_a, sqrt_b;
    logic signed [W-1:0] vec_z;

    hrzm_isqrt u_sqrt_a (
        .clk  (clk),
        .en   (en),
        .v_in (l_a_reg),
        .root (sqrt_a)
    );

    hrzm_isqrt u_sqrt_b (
        .clk  (clk),
        .en   (en),
        .v_in (l_b_reg),
        .root (sqrt_b)
    );

    hrzm_cordic u_vec (
        .clk     (clk),
        .en      (en),
        .vect    (1'b1),
        .x_in    (W'(sqrt_b)),
        .y_in    (W'(sqrt_a)),
        .z_in    ('0),
        .tag_in  (1'b0),
        .x_out   (),
        .y_out   (),
        .z_out   (vec_z),
        .tag_out ()
    );

    // ------------------------------------------------------------------
    // stages M..O: arc, scale to 1/256 nm with rounding, saturate
    // ------------------------------------------------------------------
    logic [31:0] m_arc_reg;
    logic [59:0] n_prod_reg;
    logic [21:0] o_dist_reg;
    logic [60:0] o_rnd;
    logic [22:0] o_dq;

    assign o_rnd = 61'(n_prod_reg) + (61'd1 << 37);
    assign o_dq  = o_rnd[60:38];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // negative arc counts as zero
            m_arc_reg  <= vec_z[W-1] ? 32'd0 : {vec_z[30:0], 1'b0};
            n_prod_reg <= 60'(m_arc_reg) * 60'(hrzm_pkg::RADIUS_Q16);
            o_dist_reg <= (o_dq > 23'(hrzm_pkg::DIST_MAX)) ? hrzm_pkg::DIST_MAX
                                                           : o_dq[21:0];
        end
    end

    // ------------------------------------------------------------------
    // output register: zone classification
    // ------------------------------------------------------------------
    side_t              o_side;
    hrzm_pkg::zone_t    zone_next;
    logic [21:0]        out_dist_reg;
    logic signed [17:0] out_alt_reg;
    hrzm_pkg::zone_t    out_zone_reg;

    assign o_side = side_reg[SL-1];

    always_comb
    begin
        if (o_dist_reg > inner_reg && o_dist_reg <= outer_reg && o_side.le_ceil)
            zone_next = hrzm_pkg::ZONE_RING;
        else if (o_dist_reg <= outer_reg && o_side.ge_floor && o_side.le_ceil
                 && o_side.vr_pos)
            zone_next = hrzm_pkg::ZONE_CLIMB;
        else if (o_dist_reg > outer_reg || (o_dist_reg < inner_reg && !o_side.le_ceil))
            zone_next = hrzm_pkg::ZONE_LEFT;
        else
            zone_next = hrzm_pkg::ZONE_NONE;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_dist_reg <= o_dist_reg;
            out_alt_reg  <= o_side.alt_ft;
            out_zone_reg <= zone_next;
        end
    end

    assign result.valid       = out_vld_reg;
    assign result.distance_nm = out_dist_reg;
    assign result.alt_ft      = out_alt_reg;
    assign result.zone_event  = out_zone_reg;

endmodule

@@ rtl/hrzm_checker.sv @@
// ----------------------------------------------------------------------------
// hrzm_checker
// port-level checks on the range and zone monitor, bound to the top level
// ----------------------------------------------------------------------------
module hrzm_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic        [21:0] distance_nm,
    input logic signed [17:0] alt_ft,
    input logic        [1:0]  zone_event,
    input logic               cfg_ready
);

    // a waiting result transaction holds still
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(distance_nm)
                                    && $stable(alt_ft) && $stable(zone_event))
        else $error("result changed while stalled");

    // reports are refused only while a finished result is blocked
    a_report_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("report refused without output back-pressure");

    // distance saturates at the cap
    a_dist_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> distance_nm <= hrzm_pkg::DIST_MAX)
        else $error("distance above cap");

    // register writes are never held off
    a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid || !in_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind haversine_range_zone_monitor_core hrzm_checker u_hrzm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (report.valid),
    .in_ready    (report.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .distance_nm (result.distance_nm),
    .alt_ft      (result.alt_ft),
    .zone_event  (result.zone_event),
    .cfg_ready   (cfg.ready)
);

@@ sim/haversine_range_zone_monitor_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haversine_range_zone_monitor_checker
// watches the report, result and configuration channels, predicts range,
// feet and zone event of each report and compares every result in order
// ----------------------------------------------------------------------------
module haversine_range_zone_monitor_checker (
    input  logic   clk,
    input  logic   rst_n,
    hrzm_report_if report,
    hrzm_result_if result,
    hrzm_cfg_if    cfg,
    output int     mismatches,
    output int     outstanding
);

    typedef struct {
        logic        [21:0] distance_nm;
        logic signed [17:0] alt_ft;
        hrzm_pkg::zone_t    zone_event;
    } range_rec_t;

    range_rec_t range_q[$];

    // shadow registers
    longint ref_lat_q, ref_lon_q, outer_q, inner_q, ceil_q, floor_q;

    // fixed-point constants, built from series
    longint arctan_tab[32];
    longint pi_r, deg_k, gain_inv;

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint arctan_inv_q62(input longint unsigned n);
        longint unsigned t, n2, k;
        longint sum;
        t   = (64'd1 << 62) / n;
        n2  = n * n;
        sum = longint'(t);
        k   = 1;
        forever begin
            t = t / n2;
            if (t == 0)
                break;
            if (k[0])
                sum = sum - longint'(t / (2 * k + 1));
            else
                sum = sum + longint'(t / (2 * k + 1));
            k++;
        end
        return sum;
    endfunction

    function automatic longint round_shift(input longint v, input int s);
        longint half;
        half = longint'(1) << (s - 1);
        if (v >= 0)
            return (v + half) >>> s;
        return -((-v + half) >>> s);
    endfunction

    task automatic rotate(input longint ang, output longint c, output longint s);
        longint two_pi, half_pi, r, x, y, dx, dy;
        bit flip;
        two_pi  = 2 * pi_r;
        half_pi = pi_r / 2;
        r       = ang % two_pi;
        x       = gain_inv;
        y       = 0;
        flip    = 0;
        if (r > pi_r)
            r -= two_pi;
        else if (r <= -pi_r)
            r += two_pi;
        if (r > half_pi) begin
            r -= pi_r;
            flip = 1;
        end
        else if (r < -half_pi) begin
            r += pi_r;
            flip = 1;
        end
        for (int i = 0; i < hrzm_pkg::CORDIC_N; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (r >= 0) begin
                x -= dx;
                y += dy;
                r -= arctan_tab[i];
            end
            else begin
                x += dx;
                y -= dy;
                r += arctan_tab[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic longint vector_angle(input longint y, input longint x);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < hrzm_pkg::CORDIC_N; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx;
                y -= dy;
                z += arctan_tab[i];
            end
            else begin
                x -= dx;
                y += dy;
                z -= arctan_tab[i];
            end
        end
        return z;
    endfunction

    task automatic predict_range(input logic signed [27:0] lat_in,
                                 input logic signed [28:0] lon_in,
                                 input logic signed [15:0] alt_in,
                                 input logic signed [15:0] vr_in,
                                 output range_rec_t rec);
        longint lat, lon, alt, vr, unused, s1, s2, cp, cr, a, arc, dist_nm, ftm, ft;
        longint ceil_m, floor_m;
        longint unsigned rq;
        hrzm_pkg::zone_t ev;
        lat = lat_in;
        lon = lon_in;
        alt = alt_in;
        vr  = vr_in;
        rq  = (64'd6371 * 1000 * 65536 + 926) / 1852;
        rotate(round_shift((lat - ref_lat_q) * deg_k, 27), unused, s1);
        rotate(round_shift((lon - ref_lon_q) * deg_k, 27), unused, s2);
        rotate(round_shift(lat * deg_k, 26), cp, unused);
        rotate(round_shift(ref_lat_q * deg_k, 26), cr, unused);
        a = s1 * s1 + round_shift(cp * cr, 30) * round_shift(s2 * s2, 30);
        if (a < 0)
            a = 0;
        if (a > (longint'(1) << 60))
            a = longint'(1) << 60;
        arc = 2 * vector_angle(longint'(floor_sqrt(a)),
                               longint'(floor_sqrt((longint'(1) << 60) - a)));
        if (arc < 0)
            arc = 0;
        dist_nm = longint'((longint'(arc) * rq + (64'd1 << 37)) >> 38);
        if (dist_nm > 2766667)
            dist_nm = 2766667;
        ftm = alt * 3281;
        ft  = ftm >= 0 ? (ftm + 500) / 1000 : -((-ftm + 500) / 1000);
        ceil_m  = ceil_q * 1000;
        floor_m = floor_q * 1000;
        if (dist_nm > inner_q && dist_nm <= outer_q && ftm <= ceil_m)
            ev = hrzm_pkg::ZONE_RING;
        else if (dist_nm <= outer_q && ftm >= floor_m && ftm <= ceil_m && vr > 0)
            ev = hrzm_pkg::ZONE_CLIMB;
        else if (dist_nm > outer_q || (dist_nm < inner_q && ftm > ceil_m))
            ev = hrzm_pkg::ZONE_LEFT;
        else
            ev = hrzm_pkg::ZONE_NONE;
        rec.distance_nm = dist_nm[21:0];
        rec.alt_ft      = ft[17:0];
        rec.zone_event  = ev;
    endtask

    initial
    begin
        longint quarter;
        longint unsigned p;
        quarter  = 4 * arctan_inv_q62(5) - arctan_inv_q62(239);
        pi_r     = (quarter + (longint'(1) << 29)) >>> 30;
        deg_k    = ((quarter >>> 24) + 90) / 180;
        arctan_tab[0] = (quarter + (longint'(1) << 31)) >>> 32;
        for (int i = 1; i < 32; i++)
            arctan_tab[i] = (arctan_inv_q62(64'd1 << i) + (longint'(1) << 31)) >>> 32;
        p = 64'd1 << 60;
        for (int i = 0; i < hrzm_pkg::CORDIC_N; i++)
            p = p - p / ((64'd1 << (2 * i)) + 1);
        gain_inv = longint'(floor_sqrt(p));
    end

    assign outstanding = range_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        range_rec_t rec, want;
        if (!rst_n) begin
            ref_lat_q  <= 45798759;
            ref_lon_q  <= -83501672;
            outer_q    <= 2048;
            inner_q    <= 1920;
            ceil_q     <= 3000;
            floor_q    <= 2500;
            mismatches <= 0;
            range_q.delete();
        end
        else begin
            if (cfg.valid && cfg.ready) begin
                case (hrzm_pkg::cfg_idx_t'(cfg.index))
                    hrzm_pkg::REG_REF_LAT:
                        ref_lat_q <= longint'($signed(cfg.data[27:0]));
                    hrzm_pkg::REG_REF_LON:
                        ref_lon_q <= longint'($signed(cfg.data[28:0]));
                    hrzm_pkg::REG_OUTER_RADIUS: outer_q <= cfg.data[21:0];
                    hrzm_pkg::REG_INNER_RADIUS: inner_q <= cfg.data[21:0];
                    hrzm_pkg::REG_CEILING_FT:   ceil_q  <= cfg.data[16:0];
                    hrzm_pkg::REG_FLOOR_FT:     floor_q <= cfg.data[16:0];
                    default: ;
                endcase
            end
            if (report.valid && report.ready) begin
                predict_range(report.lat_deg, report.lon_deg, report.alt_m,
                              report.vert_rate, rec);
                range_q.push_back(rec);
            end
            if (result.valid && result.ready) begin
                if (range_q.size() == 0) begin
                    $error("result transaction with nothing expected");
                    mismatches <= mismatches + 1;
                end
                else begin
                    want = range_q.pop_front();
                    if (result.distance_nm !== want.distance_nm ||
                        result.alt_ft !== want.alt_ft ||
                        result.zone_event !== want.zone_event)
                        mismatches <= mismatches + 1;
                    if (result.distance_nm !== want.distance_nm)
                        $error("distance_nm expected %0d actual %0d",
                               want.distance_nm, result.distance_nm);
                    if (result.alt_ft !== want.alt_ft)
                        $error("alt_ft expected %0d actual %0d",
                               want.alt_ft, result.alt_ft);
                    if (result.zone_event !== want.zone_event)
                        $error("zone_event expected %0d actual %0d",
                               want.zone_event, result.zone_event);
                end
            end
        end
    end

endmodule

@@ sim/haversine_range_zone_monitor_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// haversine_range_zone_monitor_core_test
// drives position reports and register writes into the range and zone
// monitor under several idle and stall mixes; the checker judges results
// ----------------------------------------------------------------------------
module haversine_range_zone_monitor_core_test;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 120;   // longer than the pipeline
    localparam int LONG_HOLD   = 400;

    logic clk;
    logic rst_n;

    hrzm_report_if report ();
    hrzm_result_if result ();
    hrzm_cfg_if    cfg ();

    int mismatches;
    int outstanding;

    // idle mix of the current phase, in percent
    int send_idle;
    int stall_pct;

    // long receiver hold-off, counted by the receiver process itself
    logic hold_go;
    int   hold_cnt;

    // copy of the reference point and limits, used to aim reports
    longint aim_lat, aim_lon, aim_ceil, aim_floor, aim_outer;

    int cycles;

    haversine_range_zone_monitor_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .report (report),
        .result (result),
        .cfg    (cfg)
    );

    haversine_range_zone_monitor_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .report      (report),
        .result      (result),
        .cfg         (cfg),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // run watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: random stalls, plus the long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_go && hold_cnt < LONG_HOLD) begin
            result.ready <= 1'b0;
            hold_cnt     <= hold_cnt + 1;
        end
        else begin
            if (!hold_go)
                hold_cnt <= 0;
            result.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // one register write transaction, valid left high for a following write
    task automatic reg_write(input hrzm_pkg::cfg_idx_t idx, input longint value);
        bit took;
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value[28:0];
        do begin
            @(negedge clk);
            took = cfg.ready;
            @(posedge clk);
        end while (!took);
        case (idx)
            hrzm_pkg::REG_REF_LAT:      aim_lat   = value;
            hrzm_pkg::REG_REF_LON:      aim_lon   = value;
            hrzm_pkg::REG_OUTER_RADIUS: aim_outer = value;
            hrzm_pkg::REG_CEILING_FT:   aim_ceil  = value;
            hrzm_pkg::REG_FLOOR_FT:     aim_floor = value;
            default: ;
        endcase
    endtask

    // one report transaction, valid left high for a following report
    task automatic send_report(input logic signed [27:0] lat, input logic signed [28:0] lon,
                               input logic signed [15:0] alt, input logic signed [15:0] vr);
        bit took;
        while ($urandom_range(99) < send_idle) begin
            report.valid <= 1'b0;
            @(posedge clk);
        end
        report.valid     <= 1'b1;
        report.lat_deg   <= lat;
        report.lon_deg   <= lon;
        report.alt_m     <= alt;
        report.vert_rate <= vr;
        do begin
            @(negedge clk);
            took = report.ready;
            @(posedge clk);
        end while (!took);
    endtask

    task automatic wait_idle();
        report.valid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // random report: mostly aimed near the reference and the altitude band,
    // the rest anywhere in range or raw bit patterns
    task automatic random_report();
        longint lat, lon, alt, span;
        int pick;
        pick = $urandom_range(99);
        span = aim_outer * 1200 / 256 + 2000;   // roughly a fifteenth of the outer radius in Q20 deg
        if (span > 20000000)
            span = 20000000;
        if (pick < 70) begin
            lat = aim_lat + longint'($urandom_range(2 * span)) - span;
            lon = aim_lon + longint'($urandom_range(2 * span)) - span;
        end
        else if (pick < 90) begin
            lat = longint'($urandom_range(188743680)) - 94371840;
            lon = longint'($urandom_range(377487360)) - 188743680;
        end
        else begin
            lat = $signed(28'($urandom));
            lon = $signed(29'($urandom));
        end
        pick = $urandom_range(99);
        if (pick < 40)
            alt = aim_ceil * 1000 / 3281 + longint'($urandom_range(60)) - 30;
        else if (pick < 70)
            alt = aim_floor * 1000 / 3281 + longint'($urandom_range(60)) - 30;
        else if (pick < 90)
            alt = longint'($urandom_range(20500)) - 500;
        else
            alt = $signed(16'($urandom));
        send_report(lat[27:0], lon[28:0], alt[15:0], 16'($urandom));
    endtask

    task automatic config_set(input longint lat, input longint lon, input longint outer,
                              input longint inner, input longint ceil_v, input longint floor_v);
        reg_write(hrzm_pkg::REG_REF_LAT, lat);
        reg_write(hrzm_pkg::REG_REF_LON, lon);
        reg_write(hrzm_pkg::REG_OUTER_RADIUS, outer);
        reg_write(hrzm_pkg::REG_INNER_RADIUS, inner);
        reg_write(hrzm_pkg::REG_CEILING_FT, ceil_v);
        reg_write(hrzm_pkg::REG_FLOOR_FT, floor_v);
        cfg.valid <= 1'b0;
    endtask

    initial
    begin
        int idles[4];
        int stalls[4];
        rst_n            = 1'b0;
        send_idle        = 0;
        stall_pct        = 0;
        hold_go          = 1'b0;
        report.valid     = 1'b0;
        report.lat_deg   = '0;
        report.lon_deg   = '0;
        report.alt_m     = '0;
        report.vert_rate = '0;
        cfg.valid        = 1'b0;
        cfg.index        = hrzm_pkg::REG_REF_LAT;
        cfg.data         = '0;
        aim_lat   = 45798759;
        aim_lon   = -83501672;
        aim_outer = 2048;
        aim_ceil  = 3000;
        aim_floor = 2500;
        idles  = '{0, 58, 0, 22};
        stalls = '{0, 0, 58, 22};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, same point, poles, date line, antipode,
        // altitude and vertical rate extremes, raw out-of-range coordinates
        send_report(28'sd45798759, -29'sd83501672, 16'sd0, 16'sd0);
        send_report(28'sd45798759, -29'sd83501672, 16'sd914, 16'sd1);
        send_report(28'sd45798759, -29'sd83501672, 16'sd762, 16'sd5);
        send_report(28'sd45798759, -29'sd83501672, 16'sd2000, -16'sd1);
        send_report(28'sd45798759 + 28'sd130000, -29'sd83501672, 16'sd500, 16'sd1);
        send_report(28'sd45798759 + 28'sd145000, -29'sd83501672, 16'sd900, 16'sd1);
        send_report(28'sd94371840, 29'sd188743680, 16'sd20000, 16'sd32767);
        send_report(-28'sd94371840, -29'sd188743680, -16'sd500, -16'sd32768);
        send_report(-28'sd45798759, 29'sd105241998, 16'sd100, 16'sd0);
        send_report(28'sh7ffffff, 29'sh0fffffff, 16'sh7fff, 16'sh7fff);
        send_report(28'sh8000000, 29'sh10000000, 16'sh8000, 16'sh8000);
        send_report(28'sd0, 29'sd0, 16'sd0, 16'sd0);
        send_report(28'sd1, 29'sd188743680, 16'sd1, 16'sd1);
        wait_idle();
        // inverted radii and band, zero radii, extremes of every register
        config_set(94371840, 188743680, 0, 0, 0, 70000);
        send_report(28'sd94371840, 29'sd188743680, 16'sd0, 16'sd1);
        send_report(28'sd94371840, -29'sd188743680, 16'sd5, 16'sd1);
        send_report(-28'sd94371840, 29'sd0, -16'sd500, 16'sd1);
        wait_idle();
        config_set(-94371840, -188743680, 2766667, 2766667, 70000, 0);
        send_report(28'sd94371840, 29'sd188743680, 16'sd20000, 16'sd1);
        send_report(-28'sd94371840, -29'sd188743680, 16'sd21336, 16'sd1);
        send_report(28'sd0, 29'sd0, 16'sd100, -16'sd7);
        wait_idle();
        config_set(1000000, 2000000, 1000, 2000, 2000, 4000);
        send_report(28'sd1000000, 29'sd2000000, 16'sd900, 16'sd3);
        send_report(28'sd1003000, 29'sd2000000, 16'sd900, 16'sd3);
        wait_idle();

        // random phases, each under a new register setting
        for (int ph = 0; ph < 4; ph++) begin
            longint o, i;
            o = $urandom_range(8000);
            i = (ph == 3) ? o + 100 : o - longint'($urandom_range(o));
            config_set(longint'($urandom_range(180000000)) - 90000000,
                       longint'($urandom_range(377487360)) - 188743680,
                       o, i, $urandom_range(40000), $urandom_range(40000));
            send_idle = idles[ph];
            stall_pct = stalls[ph];
            for (int k = 0; k < 145; k++)
                random_report();
            wait_idle();
        end

        // back-pressure: receiver holds off while reports keep coming
        config_set(45798759, -83501672, 2048, 1920, 3000, 2500);
        send_idle = 0;
        stall_pct = 0;
        hold_go   <= 1'b1;
        for (int k = 0; k < 200; k++)
            random_report();
        hold_go   <= 1'b0;
        wait_idle();

        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
